[hdl/crt_pkg.sv]
package crt_pkg;

   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 25;
   // bitmap RAM word: 32 chunk flags per word
   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_PIECE = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   localparam logic KIND_ACK    = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_PIECE_WR,
      ST_SCAN,
      ST_RESP
   } crt_state_type;

endpackage

[hdl/crt_bitmap_ram.sv]
module crt_bitmap_ram
   import crt_pkg::*;
#(
   parameter int DEPTH = 512,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/crt_zero_find.sv]
module crt_zero_find
   import crt_pkg::*;
(
   input  logic [WORD_BITS-1:0]  bits,
   output logic                  found,
   output logic [WORD_SHIFT-1:0] pos
);

   // lowest clear bit wins
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (!bits[j]) begin
            found = 1'b1;
            pos   = WORD_SHIFT'(j);
         end
      end
   end

endmodule

[hdl/chunk_receive_tracker_unit.sv]
// A piece beat gives no result; a start beat clears the bitmap words of the upload and
// then gives the ack; a query beat scans up to the first missing chunk and then gives
// the report (32 chunks per word).
// Throughput: one beat at a time; the bitmap RAM port sets the pace, one word a cycle.
// Reset: synchronous, active high; clears control state and base/size/count.
// The bitmap RAM is not cleared by reset: every start clears the words it uses.
module chunk_receive_tracker_unit
   import crt_pkg::*;
#(
   parameter int MAX_CHUNKS  = 16384,
   parameter int CHUNK_SHIFT = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] address, [56:32] size, [63:57] zero
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] resp_address, [56:32] resp_size,
                                    // [57] size_clamped, [63:58] zero
   output logic        rsp_tuser    // [0] resp_kind
);

   localparam int          CHUNK_BYTES = 1 << CHUNK_SHIFT;
   localparam int          CNT_W       = $clog2(MAX_CHUNKS + 1);
   localparam int          WORDS       = (MAX_CHUNKS + WORD_BITS - 1) / WORD_BITS;
   localparam int          AW          = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [63:0] CAP         = 64'(MAX_CHUNKS) << CHUNK_SHIFT;

   crt_state_type state_ff, state_in;

   // upload descriptor
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [SIZE_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [AW-1:0]     last_word_ff, last_word_in;

   // walk pointer for clear / scan, target for piece update
   logic [AW-1:0]         word_ff, word_in;
   logic [WORD_SHIFT-1:0] bit_ff, bit_in;

   // pending result
   logic              res_kind_ff, res_kind_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [SIZE_W-1:0] res_size_ff, res_size_in;
   logic              res_clamp_ff, res_clamp_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [SIZE_W-1:0] rsp_size_ff, rsp_size_in;
   logic              rsp_clamp_ff, rsp_clamp_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;

   logic              req_fire;
   logic [1:0]        in_func;
   logic [ADDR_W-1:0] in_addr;
   logic [SIZE_W-1:0] in_size;

   logic              start_clamped;
   logic [SIZE_W-1:0] start_size;
   logic [SIZE_W:0]   start_count_full;
   logic [CNT_W-1:0]  start_count;
   logic [31:0]       start_nm1;
   logic [AW-1:0]     start_last_word;

   logic [31:0]           piece_idx;
   logic                  piece_hit;
   logic [AW-1:0]         piece_word;
   logic [WORD_SHIFT-1:0] piece_bit;

   logic                  at_last;
   logic [WORD_SHIFT-1:0] last_bits;
   logic [WORD_BITS-1:0]  scan_word;
   logic                  found;
   logic [WORD_SHIFT-1:0] found_pos;
   logic [31:0]           found_idx;
   logic [ADDR_W-1:0]     found_addr;
   logic [CHUNK_SHIFT-1:0] rem;
   logic [SIZE_W-1:0]     found_len;
   logic                  slot_free;

   assign req_fire = req_tvalid & req_tready;
   assign in_func  = req_tuser;
   assign in_addr  = req_tdata[31:0];
   assign in_size  = req_tdata[56:32];

   // start: clamp to capacity, chunk count rounded up, last bitmap word
   assign start_clamped    = 64'(in_size) > CAP;
   assign start_size       = start_clamped ? CAP[SIZE_W-1:0] : in_size;
   assign start_count_full = ({1'b0, start_size} + (SIZE_W + 1)'(CHUNK_BYTES - 1))
                             >> CHUNK_SHIFT;
   assign start_count      = start_count_full[CNT_W-1:0];
   assign start_nm1        = 32'(start_count) - 32'd1;
   assign start_last_word  = start_nm1[AW+WORD_SHIFT-1:WORD_SHIFT];

   // piece: wrapping offset from base; below base wraps high and misses
   assign piece_idx  = (in_addr - base_ff) >> CHUNK_SHIFT;
   assign piece_hit  = piece_idx < 32'(count_ff);
   assign piece_word = piece_idx[AW+WORD_SHIFT-1:WORD_SHIFT];
   assign piece_bit  = piece_idx[WORD_SHIFT-1:0];

   // scan: flags past the last chunk read as received
   assign at_last   = word_ff == last_word_ff;
   assign last_bits = count_ff[WORD_SHIFT-1:0];

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         scan_word[j] = ram_rdata[j] |
                        (at_last && (last_bits != '0) && (WORD_SHIFT'(j) >= last_bits));
      end
   end

   crt_zero_find u_zero_find (
      .bits  (scan_word),
      .found (found),
      .pos   (found_pos)
   );

   assign found_idx  = 32'({word_ff, found_pos});
   assign found_addr = base_ff + (found_idx << CHUNK_SHIFT);
   assign rem        = total_ff[CHUNK_SHIFT-1:0];
   // short tail only when the missing chunk is the last one and size is not a whole chunk
   assign found_len  = (((found_idx + 32'd1) == 32'(count_ff)) && (rem != '0)) ?
                       SIZE_W'(rem) : SIZE_W'(CHUNK_BYTES);

   assign slot_free  = !rsp_valid_ff || rsp_tready;

   crt_bitmap_ram #(
      .DEPTH (WORDS),
      .AW    (AW)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (in_func)
                  FUNC_START: state_in = (start_count == '0) ? ST_RESP : ST_CLEAR;
                  FUNC_PIECE: state_in = piece_hit ? ST_PIECE_WR : ST_IDLE;
                  FUNC_QUERY: state_in = (count_ff == '0) ? ST_RESP : ST_SCAN;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (at_last) state_in = ST_RESP;
         end
         ST_PIECE_WR: state_in = ST_IDLE;
         ST_SCAN: begin
            if (found || at_last) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      base_in      = base_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      last_word_in = last_word_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      res_kind_in  = res_kind_ff;
      res_addr_in  = res_addr_ff;
      res_size_in  = res_size_ff;
      res_clamp_in = res_clamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_clamp_in = rsp_clamp_ff;
      ram_we       = 1'b0;
      ram_waddr    = word_ff;
      ram_wdata    = '0;
      ram_raddr    = word_ff + AW'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (in_func)
                  FUNC_START: begin
                     base_in      = in_addr;
                     total_in     = start_size;
                     count_in     = start_count;
                     last_word_in = start_last_word;
                     word_in      = '0;
                     res_kind_in  = KIND_ACK;
                     res_addr_in  = in_addr;
                     res_size_in  = start_size;
                     res_clamp_in = start_clamped;
                  end
                  FUNC_PIECE: begin
                     word_in   = piece_word;
                     bit_in    = piece_bit;
                     ram_raddr = piece_word;
                  end
                  FUNC_QUERY: begin
                     word_in      = '0;
                     ram_raddr    = '0;
                     res_kind_in  = KIND_REPORT;
                     res_addr_in  = '0;
                     res_size_in  = '0;
                     res_clamp_in = 1'b0;
                  end
                  default: begin
                     word_in = word_ff;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            ram_we  = 1'b1;
            word_in = word_ff + AW'(1);
         end
         ST_PIECE_WR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_ff);
         end
         ST_SCAN: begin
            if (found) begin
               res_addr_in = found_addr;
               res_size_in = found_len;
            end else if (!at_last) begin
               word_in = word_ff + AW'(1);
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_addr_in  = res_addr_ff;
               rsp_size_in  = res_size_ff;
               rsp_clamp_in = res_clamp_ff;
            end
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         last_word_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         last_word_ff <= last_word_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      bit_ff       <= bit_in;
      res_kind_ff  <= res_kind_in;
      res_addr_ff  <= res_addr_in;
      res_size_ff  <= res_size_in;
      res_clamp_ff <= res_clamp_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_clamp_ff <= rsp_clamp_in;
   end

   // one beat in flight; the output register decouples the result side
   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {6'd0, rsp_clamp_ff, rsp_size_ff, rsp_addr_ff};

`ifndef SYNTHESIS
   a_start_query_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (in_func == FUNC_START || in_func == FUNC_QUERY)) |=>
      (state_ff != ST_IDLE))
      else $error("start/query beat did not leave idle");

   a_clear_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (word_ff <= last_word_ff))
      else $error("clear sweep past last bitmap word");

   a_resp_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && slot_free) |=> (rsp_tvalid && state_ff == ST_IDLE))
      else $error("pending result not moved to output register");
`endif

endmodule
